// ===== hw/rtl/ssa_pkg.sv =====
// ----------------------------------------------------------------------------
// ssa_pkg
// Shared widths, constants, pipeline stage types and helper functions of the
// surface slope and aspect unit.
// ----------------------------------------------------------------------------
package ssa_pkg;

   // default geometry
   localparam int GRID_CELLS_DEF   = 1024;
   localparam int ANGLE_STAGES_DEF = 16;

   // field widths
   localparam int NORM_W     = 16;
   localparam int POS_W      = 24;
   localparam int HALF_W     = 23;
   localparam int SCALE_W    = 24;
   localparam int SLOPE_W    = 14;
   localparam int ASPECT_W   = 15;
   localparam int CELL_W     = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   // internal widths
   localparam int SUM_W      = POS_W + 1;     // pos + half extent, signed
   localparam int HSQ_W      = 32;            // nx^2 + ny^2
   localparam int RAD_W      = HSQ_W + 16;    // radicand, hsq * 65536
   localparam int ROOT_W     = RAD_W / 2;
   localparam int SQRT_STEPS = ROOT_W;
   localparam int REM_W      = ROOT_W + 2;
   localparam int XY_W       = 27;            // CORDIC x/y, signed
   localparam int Z_W        = 25;            // CORDIC angle, deg * 65536, signed
   localparam int ACC_W      = 26;            // final angle, unsigned

   // angles in degrees * 65536
   localparam logic [ACC_W-1:0] DEG90_Q16  = 26'd5898240;
   localparam logic [ACC_W-1:0] DEG180_Q16 = 26'd11796480;
   localparam logic [ACC_W-1:0] DEG270_Q16 = 26'd17694720;
   localparam logic [ACC_W-1:0] DEG360_Q16 = 26'd23592960;
   localparam logic [ACC_W-1:0] Q6_ROUND   = 26'd512;
   localparam logic [ACC_W-11:0] Q6_FULL_TURN = 16'd23040;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HALF_EXTENT_X = 2'd0,
      CSR_HALF_EXTENT_Y = 2'd1,
      CSR_CELL_SCALE_X  = 2'd2,
      CSR_CELL_SCALE_Y  = 2'd3
   } csr_index_type;

   // request data that rides along the pipe
   typedef struct packed {
      logic signed [NORM_W-1:0] nx;
      logic signed [NORM_W-1:0] ny;
      logic signed [NORM_W-1:0] nz;
      logic [CELL_W-1:0]        cell_x;
      logic [CELL_W-1:0]        cell_y;
   } side_type;

   // one square root stage
   typedef struct packed {
      logic [RAD_W-1:0]  rad;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
      side_type          side;
   } sqrt_stage_type;

   // one CORDIC vectoring lane
   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
      logic                   force90;
   } lane_type;

   // one angle stage: slope lane, aspect lane, side data
   typedef struct packed {
      lane_type slope;
      lane_type aspect;
      side_type side;
   } angle_stage_type;

   // atan(2^-i) in degrees * 65536
   function automatic logic [Z_W-1:0] atan_q16(input logic [4:0] idx);
      logic [Z_W-1:0] r;
      case (idx)
         5'd0:  r = 25'd2949120;
         5'd1:  r = 25'd1740967;
         5'd2:  r = 25'd919879;
         5'd3:  r = 25'd466945;
         5'd4:  r = 25'd234379;
         5'd5:  r = 25'd117304;
         5'd6:  r = 25'd58666;
         5'd7:  r = 25'd29335;
         5'd8:  r = 25'd14668;
         5'd9:  r = 25'd7334;
         5'd10: r = 25'd3667;
         5'd11: r = 25'd1833;
         5'd12: r = 25'd917;
         5'd13: r = 25'd458;
         5'd14: r = 25'd229;
         5'd15: r = 25'd115;
         5'd16: r = 25'd57;
         5'd17: r = 25'd29;
         5'd18: r = 25'd14;
         5'd19: r = 25'd7;
         5'd20: r = 25'd4;
         5'd21: r = 25'd2;
         5'd22: r = 25'd1;
         default: r = 25'd0;
      endcase
      return r;
   endfunction

   // magnitude of a normal component
   function automatic logic [NORM_W:0] abs_norm(input logic signed [NORM_W-1:0] v);
      logic signed [NORM_W:0] ve;
      ve = {v[NORM_W-1], v};
      return v[NORM_W-1] ? (NORM_W+1)'(-ve) : (NORM_W+1)'(ve);
   endfunction

endpackage

// ===== hw/rtl/ssa_if.sv =====
// ----------------------------------------------------------------------------
// ssa_req_if / ssa_rsp_if
// Valid/ready channels carrying requests and results of the slope unit.
// ----------------------------------------------------------------------------
interface ssa_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [ssa_pkg::NORM_W-1:0]    normal_x;
   logic signed [ssa_pkg::NORM_W-1:0]    normal_y;
   logic signed [ssa_pkg::NORM_W-1:0]    normal_z;
   logic signed [ssa_pkg::POS_W-1:0]     local_x;
   logic signed [ssa_pkg::POS_W-1:0]     local_y;

   modport source (output valid, normal_x, normal_y, normal_z, local_x, local_y,
                   input ready);
   modport sink   (input valid, normal_x, normal_y, normal_z, local_x, local_y,
                   output ready);
endinterface

interface ssa_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [ssa_pkg::SLOPE_W-1:0]     slope_deg;
   logic [ssa_pkg::ASPECT_W-1:0]    aspect_deg;
   logic [ssa_pkg::CELL_W-1:0]      cell_x;
   logic [ssa_pkg::CELL_W-1:0]      cell_y;

   modport source (output valid, slope_deg, aspect_deg, cell_x, cell_y,
                   input ready);
   modport sink   (input valid, slope_deg, aspect_deg, cell_x, cell_y,
                   output ready);
endinterface

// ===== hw/rtl/ssa_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// ssa_sqrt_cell
// One restoring square root step: takes two radicand bits, yields one root
// bit, and passes the partial result to the next cell.
// ----------------------------------------------------------------------------
module ssa_sqrt_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  ssa_pkg::sqrt_stage_type in_stage,
   output logic                    out_valid,
   output ssa_pkg::sqrt_stage_type out_stage
);

   logic                    valid_ff;
   ssa_pkg::sqrt_stage_type stage_ff;
   ssa_pkg::sqrt_stage_type stage_in;
   logic [ssa_pkg::REM_W+1:0] rem_t;
   logic [ssa_pkg::REM_W+1:0] trial;

   // bring down two bits, try subtracting 4*root+1
   always_comb begin
      rem_t = {in_stage.rem, in_stage.rad[ssa_pkg::RAD_W-1 -: 2]};
      trial = {2'b00, in_stage.root, 2'b01};
      stage_in      = in_stage;
      stage_in.rad  = in_stage.rad << 2;
      if (rem_t >= trial) begin
         stage_in.rem  = ssa_pkg::REM_W'(rem_t - trial);
         stage_in.root = {in_stage.root[ssa_pkg::ROOT_W-2:0], 1'b1};
      end else begin
         stage_in.rem  = rem_t[ssa_pkg::REM_W-1:0];
         stage_in.root = {in_stage.root[ssa_pkg::ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

// ===== hw/rtl/ssa_angle_cell.sv =====
// ----------------------------------------------------------------------------
// ssa_angle_cell
// One CORDIC vectoring micro-rotation for both the slope and aspect lanes.
// ----------------------------------------------------------------------------
module ssa_angle_cell #(
   parameter int STAGE = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  ssa_pkg::angle_stage_type in_stage,
   output logic                     out_valid,
   output ssa_pkg::angle_stage_type out_stage
);

   localparam logic [ssa_pkg::Z_W-1:0] ANGLE = ssa_pkg::atan_q16(5'(STAGE));

   logic                     valid_ff;
   ssa_pkg::angle_stage_type stage_ff;
   ssa_pkg::angle_stage_type stage_in;

   // rotate toward y = 0; a lane already on the axis stays put
   function automatic ssa_pkg::lane_type rotate(input ssa_pkg::lane_type l);
      ssa_pkg::lane_type r;
      logic signed [ssa_pkg::XY_W-1:0] xs;
      logic signed [ssa_pkg::XY_W-1:0] ys;
      r  = l;
      xs = l.x >>> STAGE;
      ys = l.y >>> STAGE;
      if (l.y[ssa_pkg::XY_W-1]) begin
         r.x = l.x - ys;
         r.y = l.y + xs;
         r.z = l.z - ANGLE;
      end else if (l.y != '0) begin
         r.x = l.x + ys;
         r.y = l.y - xs;
         r.z = l.z + ANGLE;
      end
      return r;
   endfunction

   always_comb begin
      stage_in        = in_stage;
      stage_in.slope  = rotate(in_stage.slope);
      stage_in.aspect = rotate(in_stage.aspect);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

// ===== hw/rtl/surface_slope_aspect_unit_top.sv =====
// ----------------------------------------------------------------------------
// surface_slope_aspect_unit_top
// Slope and downhill aspect of a surface normal, plus the grid cell of the
// hit position, through a square root chain and a CORDIC chain.
// ----------------------------------------------------------------------------
//   channel  dir  handshake            payload
//   req_if   in   valid/ready          normal_x/y/z, local_x/y
//   rsp_if   out  valid/ready          slope_deg, aspect_deg, cell_x, cell_y
//   csr      in   csr_we (no ready)    csr_index, csr_wdata
//
// One request per cycle while no result waits unaccepted. Stages: input register,
// product register, 24 square root cells, the CORDIC cells, output register.
// Reset (synchronous) clears all valid bits and the configuration registers.
// While a result waits unaccepted, the whole pipe holds and req_if.ready is low.
// ----------------------------------------------------------------------------
module surface_slope_aspect_unit_top #(
   parameter int GRID_CELLS   = ssa_pkg::GRID_CELLS_DEF,
   parameter int ANGLE_STAGES = ssa_pkg::ANGLE_STAGES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   ssa_req_if.sink                            req_if,
   ssa_rsp_if.source                          rsp_if,
   input  logic                               csr_we,
   input  logic [ssa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ssa_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam logic [ssa_pkg::SCALE_W-1:0] CELL_MAX = ssa_pkg::SCALE_W'(GRID_CELLS - 1);

   logic en;

   // configuration registers
   logic [ssa_pkg::HALF_W-1:0]  half_x_ff;
   logic [ssa_pkg::HALF_W-1:0]  half_y_ff;
   logic [ssa_pkg::SCALE_W-1:0] scale_x_ff;
   logic [ssa_pkg::SCALE_W-1:0] scale_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_x_ff  <= '0;
         half_y_ff  <= '0;
         scale_x_ff <= '0;
         scale_y_ff <= '0;
      end else if (csr_we) begin
         case (ssa_pkg::csr_index_type'(csr_index))
            ssa_pkg::CSR_HALF_EXTENT_X: half_x_ff  <= csr_wdata[ssa_pkg::HALF_W-1:0];
            ssa_pkg::CSR_HALF_EXTENT_Y: half_y_ff  <= csr_wdata[ssa_pkg::HALF_W-1:0];
            ssa_pkg::CSR_CELL_SCALE_X:  scale_x_ff <= csr_wdata;
            ssa_pkg::CSR_CELL_SCALE_Y:  scale_y_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // pipe advances unless a result is stuck at the output
   logic rsp_valid_ff;
   assign en           = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = en;

   // ---- stage A: capture request, offset positions ----
   logic                              a_valid_ff;
   logic signed [ssa_pkg::NORM_W-1:0] a_nx_ff, a_ny_ff, a_nz_ff;
   logic signed [ssa_pkg::SUM_W-1:0]  a_sum_x_ff, a_sum_y_ff;
   logic signed [ssa_pkg::SUM_W-1:0]  a_sum_x_in, a_sum_y_in;

   assign a_sum_x_in = ssa_pkg::SUM_W'(req_if.local_x)
                     + $signed({2'b00, half_x_ff});
   assign a_sum_y_in = ssa_pkg::SUM_W'(req_if.local_y)
                     + $signed({2'b00, half_y_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_nx_ff    <= req_if.normal_x;
         a_ny_ff    <= req_if.normal_y;
         a_nz_ff    <= req_if.normal_z;
         a_sum_x_ff <= a_sum_x_in;
         a_sum_y_ff <= a_sum_y_in;
      end
   end

   // ---- stage B: squares and cell products ----
   logic signed [2*ssa_pkg::NORM_W-1:0] sq_x, sq_y;
   logic [ssa_pkg::HSQ_W-1:0]           hsq;
   logic [2*ssa_pkg::SCALE_W-1:0]       prod_x, prod_y;
   logic [ssa_pkg::SCALE_W-1:0]         idx_x, idx_y;
   logic [ssa_pkg::CELL_W-1:0]          cell_x_c, cell_y_c;
   ssa_pkg::sqrt_stage_type             sq_stage_in;

   always_comb begin
      sq_x   = a_nx_ff * a_nx_ff;
      sq_y   = a_ny_ff * a_ny_ff;
      hsq    = ssa_pkg::HSQ_W'($unsigned(sq_x)) + ssa_pkg::HSQ_W'($unsigned(sq_y));
      prod_x = a_sum_x_ff[ssa_pkg::SCALE_W-1:0] * scale_x_ff;
      prod_y = a_sum_y_ff[ssa_pkg::SCALE_W-1:0] * scale_y_ff;
      idx_x  = prod_x[2*ssa_pkg::SCALE_W-1 -: ssa_pkg::SCALE_W];
      idx_y  = prod_y[2*ssa_pkg::SCALE_W-1 -: ssa_pkg::SCALE_W];
      if (idx_x > CELL_MAX) idx_x = CELL_MAX;
      if (idx_y > CELL_MAX) idx_y = CELL_MAX;
      // left of the box: first cell
      cell_x_c = (a_sum_x_ff <= 0) ? '0 : idx_x[ssa_pkg::CELL_W-1:0];
      cell_y_c = (a_sum_y_ff <= 0) ? '0 : idx_y[ssa_pkg::CELL_W-1:0];

      sq_stage_in             = '0;
      sq_stage_in.rad         = {hsq, 16'h0000};
      sq_stage_in.side.nx     = a_nx_ff;
      sq_stage_in.side.ny     = a_ny_ff;
      sq_stage_in.side.nz     = a_nz_ff;
      sq_stage_in.side.cell_x = cell_x_c;
      sq_stage_in.side.cell_y = cell_y_c;
   end

   logic                    sq_valid [ssa_pkg::SQRT_STEPS+1];
   ssa_pkg::sqrt_stage_type sq_stage [ssa_pkg::SQRT_STEPS+1];
   logic                    b_valid_ff;
   ssa_pkg::sqrt_stage_type b_stage_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_stage_ff <= sq_stage_in;
      end
   end

   assign sq_valid[0] = b_valid_ff;
   assign sq_stage[0] = b_stage_ff;

   // ---- square root chain: h = isqrt(hsq * 65536) ----
   for (genvar i = 0; i < ssa_pkg::SQRT_STEPS; i++) begin : g_sqrt
      ssa_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (sq_valid[i]),
         .in_stage  (sq_stage[i]),
         .out_valid (sq_valid[i+1]),
         .out_stage (sq_stage[i+1])
      );
   end

   // ---- CORDIC entry: first-quadrant vectors ----
   logic                     ang_valid [ANGLE_STAGES+1];
   ssa_pkg::angle_stage_type ang_stage [ANGLE_STAGES+1];
   ssa_pkg::sqrt_stage_type  sq_last;
   ssa_pkg::angle_stage_type ang_entry;

   assign sq_last = sq_stage[ssa_pkg::SQRT_STEPS];

   always_comb begin
      ang_entry                = '0;
      ang_entry.side           = sq_last.side;
      ang_entry.slope.x        = ssa_pkg::XY_W'({ssa_pkg::abs_norm(sq_last.side.nz), 8'h00});
      ang_entry.slope.y        = ssa_pkg::XY_W'(sq_last.root);
      ang_entry.slope.force90  = (ang_entry.slope.x == '0) && (ang_entry.slope.y != '0);
      ang_entry.aspect.x       = ssa_pkg::XY_W'({ssa_pkg::abs_norm(sq_last.side.nx), 8'h00});
      ang_entry.aspect.y       = ssa_pkg::XY_W'({ssa_pkg::abs_norm(sq_last.side.ny), 8'h00});
      ang_entry.aspect.force90 = (ang_entry.aspect.x == '0) && (ang_entry.aspect.y != '0);
   end

   assign ang_valid[0] = sq_valid[ssa_pkg::SQRT_STEPS];
   assign ang_stage[0] = ang_entry;

   for (genvar i = 0; i < ANGLE_STAGES; i++) begin : g_angle
      ssa_angle_cell #(.STAGE(i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (ang_valid[i]),
         .in_stage  (ang_stage[i]),
         .out_valid (ang_valid[i+1]),
         .out_stage (ang_stage[i+1])
      );
   end

   // ---- final: fold quadrants, round to degrees * 64 ----
   ssa_pkg::angle_stage_type ang_last;
   logic [ssa_pkg::ACC_W-1:0]  ang_s, ang_a;
   logic [ssa_pkg::ACC_W-1:0]  slope_full, aspect_full;
   logic [ssa_pkg::ACC_W-1:0]  slope_rnd, aspect_rnd;
   logic [ssa_pkg::ACC_W-11:0] aspect_q6;
   logic                       nxy_zero, nz_zero, nz_neg, dx_neg, dy_neg;
   logic [ssa_pkg::SLOPE_W-1:0]  slope_in;
   logic [ssa_pkg::ASPECT_W-1:0] aspect_in;

   assign ang_last = ang_stage[ANGLE_STAGES];

   // clamp a lane's angle to 0..90, forcing 90 for a vertical vector
   function automatic logic [ssa_pkg::ACC_W-1:0] lane_angle(input ssa_pkg::lane_type l);
      logic [ssa_pkg::ACC_W-1:0] r;
      if (l.force90) begin
         r = ssa_pkg::DEG90_Q16;
      end else if (l.z[ssa_pkg::Z_W-1]) begin
         r = '0;
      end else if (ssa_pkg::ACC_W'(l.z) > ssa_pkg::DEG90_Q16) begin
         r = ssa_pkg::DEG90_Q16;
      end else begin
         r = ssa_pkg::ACC_W'(l.z);
      end
      return r;
   endfunction

   always_comb begin
      ang_s    = lane_angle(ang_last.slope);
      ang_a    = lane_angle(ang_last.aspect);
      nxy_zero = (ang_last.side.nx == '0) && (ang_last.side.ny == '0);
      nz_zero  = (ang_last.side.nz == '0);
      nz_neg   = ang_last.side.nz[ssa_pkg::NORM_W-1];
      // downhill direction flips with a downward normal
      dx_neg   = nz_neg ? (!ang_last.side.nx[ssa_pkg::NORM_W-1] && ang_last.side.nx != '0)
                        : ang_last.side.nx[ssa_pkg::NORM_W-1];
      dy_neg   = nz_neg ? (!ang_last.side.ny[ssa_pkg::NORM_W-1] && ang_last.side.ny != '0)
                        : ang_last.side.ny[ssa_pkg::NORM_W-1];

      if (nxy_zero && nz_zero) begin
         slope_full = ssa_pkg::DEG90_Q16;
      end else if (nz_neg) begin
         slope_full = ssa_pkg::DEG180_Q16 - ang_s;
      end else begin
         slope_full = ang_s;
      end

      if (nxy_zero) begin
         if (nz_zero)     aspect_full = '0;
         else if (nz_neg) aspect_full = ssa_pkg::DEG90_Q16;
         else             aspect_full = ssa_pkg::DEG270_Q16;
      end else if (nz_zero) begin
         aspect_full = '0;
      end else if (!dx_neg && !dy_neg) begin
         aspect_full = ang_a;
      end else if (dx_neg && !dy_neg) begin
         aspect_full = ssa_pkg::DEG180_Q16 - ang_a;
      end else if (dx_neg) begin
         aspect_full = ssa_pkg::DEG180_Q16 + ang_a;
      end else begin
         aspect_full = (ang_a == '0) ? '0 : ssa_pkg::DEG360_Q16 - ang_a;
      end

      slope_rnd  = slope_full + ssa_pkg::Q6_ROUND;
      aspect_rnd = aspect_full + ssa_pkg::Q6_ROUND;
      aspect_q6  = aspect_rnd[ssa_pkg::ACC_W-1:10];
      // rounding up to a full turn wraps to zero
      if (aspect_q6 >= ssa_pkg::Q6_FULL_TURN) begin
         aspect_q6 = aspect_q6 - ssa_pkg::Q6_FULL_TURN;
      end
      slope_in  = slope_rnd[10 +: ssa_pkg::SLOPE_W];
      aspect_in = aspect_q6[ssa_pkg::ASPECT_W-1:0];
   end

   // ---- output register ----
   logic [ssa_pkg::SLOPE_W-1:0]  slope_ff;
   logic [ssa_pkg::ASPECT_W-1:0] aspect_ff;
   logic [ssa_pkg::CELL_W-1:0]   cell_x_ff, cell_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= ang_valid[ANGLE_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         slope_ff  <= slope_in;
         aspect_ff <= aspect_in;
         cell_x_ff <= ang_last.side.cell_x;
         cell_y_ff <= ang_last.side.cell_y;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.slope_deg  = slope_ff;
   assign rsp_if.aspect_deg = aspect_ff;
   assign rsp_if.cell_x     = cell_x_ff;
   assign rsp_if.cell_y     = cell_y_ff;

`ifndef SYNTHESIS
   // slope never exceeds 180 degrees
   a_slope_range: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.slope_deg <= 14'd11520))
      else $error("slope out of range");

   // aspect is wrapped below a full turn
   a_aspect_range: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.aspect_deg < 15'd23040))
      else $error("aspect not wrapped");

   // cell index stays inside the grid
   a_cell_range: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> ((32'(rsp_if.cell_x) <= 32'(GRID_CELLS - 1))
                     && (32'(rsp_if.cell_y) <= 32'(GRID_CELLS - 1))))
      else $error("cell index past grid");

   // no result straight out of reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_if.valid)
      else $error("result after reset");
`endif

endmodule
